FILE: hw/rtl/assert_macros.svh
// assertion helpers for the fan level ramp rtl
// the checks sample on clk; the first macro also holds off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_CHK_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CHK(lbl, prop, msg)
`define ASSERT_CHK_NR(lbl, prop, msg)
`endif
`endif

FILE: hw/rtl/tflr_pkg.sv
`timescale 1ns / 1ps
package tflr_pkg;

  localparam int unsigned TEMP_W     = 12;
  localparam int unsigned MARGIN_W   = 13;
  localparam int unsigned MSUM_W     = 15;
  localparam int unsigned LOAD_W     = 9;
  localparam int unsigned CURR_W     = 15;
  localparam int unsigned CDIFF_W    = 16;
  localparam int unsigned DELAY_W    = 16;
  localparam int unsigned QUIET_W    = 2;
  localparam int unsigned DUTY_W     = 10;
  localparam int unsigned DUTY_TBL_W = 60;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned LEVEL_W    = 3;
  localparam int unsigned LLVL_W     = 4;
  localparam int unsigned AVG_CNT_W  = 10;
  localparam int unsigned AVG_SUM_W  = 19;
  localparam int unsigned ALU_W      = 20;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 60;

  localparam int unsigned NUM_LEVELS = 6;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 3'd5;
  localparam logic [LEVEL_W-1:0] QUIET_CAP = 3'd2;
  localparam logic [QUIET_W-1:0] QUIET_ULTRA = 2'd2;

  // duty * PCT_SCALE always fits in PCT_NUM_W bits
  localparam int unsigned PCT_SCALE   = 100;
  localparam int unsigned PCT_NUM_W   = 17;
  localparam int unsigned PCT_SAT     = 127;

  // averaged load at which the load level steps up by one; with offset 40,
  // step 10 and truncation toward zero the level runs from -4 to 5
  localparam int unsigned LOAD_MARKS = 9;
  localparam int unsigned LOAD_AVG_MARK [LOAD_MARKS] = '{1, 11, 21, 31, 50, 60, 70, 80, 90};
  localparam int unsigned LOAD_LEVEL_BASE = 4;
  localparam int unsigned MARK_IDX_W = 4;
  localparam int unsigned MARK_CNT_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RISE_DELAY      = 3'd0,
    CFG_FALL_DELAY      = 3'd1,
    CFG_QUIET_MODE      = 3'd2,
    CFG_TEMP_LIMIT_LOW  = 3'd3,
    CFG_TEMP_LIMIT_HIGH = 3'd4,
    CFG_CURRENT_BASE    = 3'd5,
    CFG_CURRENT_STEP    = 3'd6,
    CFG_DUTY_TABLE      = 3'd7
  } cfg_idx_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_EVAL = 6'b000010,
    ST_LOAD = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_RAMP = 6'b010000,
    ST_PCT  = 6'b100000
  } state_t;

  typedef struct packed {
    logic               en;
    logic               forced;
    logic               poff;
    logic [LEVEL_W-1:0] target;
  } ramp_cmd_t;

  // half the margin rounded down, capped at 5, taken from 5; clipped to 0..5
  function automatic logic [LEVEL_W-1:0] margin_level(input logic signed [MARGIN_W-1:0] m);
    logic signed [MARGIN_W-2:0] h;
    logic [LEVEL_W-1:0]         lvl;
    h = m[MARGIN_W-1:1];
    if (h <= 12'sd0) begin
      lvl = LEVEL_MAX;
    end else if (h >= 12'sd5) begin
      lvl = '0;
    end else begin
      lvl = LEVEL_MAX - h[LEVEL_W-1:0];
    end
    return lvl;
  endfunction

endpackage

FILE: hw/rtl/tflr_alu.sv
`timescale 1ns / 1ps
module tflr_alu (
  input  logic signed [tflr_pkg::ALU_W-1:0] a,
  input  logic signed [tflr_pkg::ALU_W-1:0] b,
  output logic signed [tflr_pkg::ALU_W-1:0] diff,
  output logic                              ge
);
  import tflr_pkg::*;

  // shared subtract and compare, used for the threshold scan and the division
  assign diff = a - b;
  assign ge   = !diff[ALU_W-1];

endmodule

FILE: hw/rtl/tflr_ramp.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tflr_ramp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tflr_pkg::ramp_cmd_t               cmd,
  input  logic [tflr_pkg::DELAY_W-1:0]      rise_delay,
  input  logic [tflr_pkg::DELAY_W-1:0]      fall_delay,
  input  logic [tflr_pkg::QUIET_W-1:0]      quiet_mode,
  output logic [tflr_pkg::LEVEL_W-1:0]      level
);
  import tflr_pkg::*;

  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic [DELAY_W-1:0] rise_r, rise_nxt;
  logic [DELAY_W-1:0] fall_r, fall_nxt;
  logic [DELAY_W-1:0] rise_inc;
  logic [DELAY_W-1:0] fall_inc;

  assign rise_inc = rise_r + DELAY_W'(1);
  assign fall_inc = fall_r + DELAY_W'(1);

  always_comb begin
    level_nxt = level_r;
    rise_nxt  = rise_r;
    fall_nxt  = fall_r;
    if (cmd.en) begin
      if (cmd.forced) begin
        level_nxt = LEVEL_MAX;
        rise_nxt  = '0;
        fall_nxt  = '0;
      end else if (level_r < cmd.target) begin
        fall_nxt = '0;
        if (rise_inc > rise_delay) begin
          rise_nxt  = '0;
          level_nxt = level_r + LEVEL_W'(1);
        end else begin
          rise_nxt = rise_inc;
        end
      end else if (level_r > cmd.target) begin
        rise_nxt = '0;
        if (fall_inc > fall_delay) begin
          fall_nxt  = '0;
          level_nxt = level_r - LEVEL_W'(1);
        end else begin
          fall_nxt = fall_inc;
        end
      end else begin
        rise_nxt = '0;
        fall_nxt = '0;
      end
      if ((quiet_mode == QUIET_ULTRA) && (level_nxt > QUIET_CAP)) begin
        level_nxt = QUIET_CAP;
      end
      // power-off test parks the stored level at zero
      if (cmd.poff) begin
        level_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
      rise_r  <= '0;
      fall_r  <= '0;
    end else begin
      level_r <= level_nxt;
      rise_r  <= rise_nxt;
      fall_r  <= fall_nxt;
    end
  end

  assign level = level_r;

  `ASSERT_CHK(a_poff_parks_zero, cmd.en && cmd.poff |=> level_r == '0, "poff level not zero")
  `ASSERT_CHK(a_ultra_cap, cmd.en && (quiet_mode == QUIET_ULTRA) |=> level_r <= QUIET_CAP, "ultra cap broken")
  `ASSERT_CHK(a_single_step, cmd.en && !cmd.forced && !cmd.poff && (quiet_mode != QUIET_ULTRA) |=> (level_r == $past(level_r)) || (level_r == $past(level_r) + LEVEL_W'(1)) || (level_r + LEVEL_W'(1) == $past(level_r)), "ramp moved more than one step")

endmodule

FILE: hw/rtl/thermal_fan_level_ramp_unit.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Fan level controller with ramp. One transaction on the in_ channel is one control
// tick; each tick gives exactly one transaction on the out_ channel (duty, percent,
// target level and applied level). Registers are written through cfg_we/cfg_index/
// cfg_wdata; the user must write them only while no tick is in flight, as the block
// does not enforce it; they take effect on the next tick. The block works on one
// tick at a time: in_ready is high only while it is idle. A tick walks a sequencer
// over one shared subtract/compare unit: an evaluate state, one to six divide steps
// for the battery current level (the divide stops at level 5), a ramp state and a
// duty/percent state. On the tick that closes the load averaging window, the same
// unit scans nine load thresholds first. A forced tick (margin sum at most zero,
// grid charge or over-temperature) skips the divide. The result sits in an output
// register, so the next tick is accepted while it waits; if out_ready stays low the
// block holds the following result in its last step until the register frees.
// Synchronous reset clears the load, target and ramp levels, the ramp delay
// counters, the sequencer and the averager, and loads the register reset values
// (current step of one).
module thermal_fan_level_ramp_unit #(
  parameter int unsigned AVG_WINDOW      = 1000,
  parameter int unsigned DUTY_FULL_SCALE = 1000
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_we,
  input  logic [tflr_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [tflr_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [tflr_pkg::TEMP_W-1:0]     in_inverter_temp,
  input  logic signed [tflr_pkg::TEMP_W-1:0]     in_converter_temp,
  input  logic signed [tflr_pkg::TEMP_W-1:0]     in_charger_temp,
  input  logic [tflr_pkg::LOAD_W-1:0]            in_load_percent,
  input  logic [tflr_pkg::CURR_W-1:0]            in_battery_current,
  input  logic                                   in_grid_charge_flag,
  input  logic                                   in_overtemp_fault,
  input  logic                                   in_power_off_test,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [tflr_pkg::DUTY_W-1:0]            out_fan_duty,
  output logic [tflr_pkg::PCT_W-1:0]             out_duty_percent,
  output logic [tflr_pkg::LEVEL_W-1:0]           out_target_level,
  output logic [tflr_pkg::LEVEL_W-1:0]           out_applied_level
);
  import tflr_pkg::*;

  // percent by reciprocal: floor(x*R >> S) is exact for x below 2**PCT_NUM_W
  localparam int unsigned PCT_SHIFT = PCT_NUM_W + $clog2(DUTY_FULL_SCALE);
  localparam longint unsigned PCT_RECIP = (64'd1 << PCT_SHIFT) / DUTY_FULL_SCALE + 64'd1;
  localparam longint unsigned PCT_MUL = PCT_SCALE * PCT_RECIP;
  localparam int unsigned PCT_MUL_W = $clog2(PCT_MUL + 64'd1);
  localparam int unsigned PCT_PROD_W = DUTY_W + PCT_MUL_W;
  localparam logic [MARK_IDX_W-1:0] THR_LAST = MARK_IDX_W'(LOAD_MARKS - 1);

  // configuration registers
  logic [DELAY_W-1:0]       rise_delay_r;
  logic [DELAY_W-1:0]       fall_delay_r;
  logic [QUIET_W-1:0]       quiet_mode_r;
  logic signed [TEMP_W-1:0] temp_lim_low_r;
  logic signed [TEMP_W-1:0] temp_lim_high_r;
  logic [CURR_W-1:0]        cur_base_r;
  logic [CURR_W-1:0]        cur_step_r;
  logic [DUTY_TBL_W-1:0]    duty_table_r;

  // sequencer and tick state
  state_t                   state_r, state_nxt;
  logic [AVG_CNT_W-1:0]     avg_cnt_r, avg_cnt_nxt;
  logic [AVG_SUM_W-1:0]     avg_sum_r, avg_sum_nxt;
  logic signed [LLVL_W-1:0] load_level_r, load_level_nxt;
  logic [MARK_IDX_W-1:0]    thr_idx_r, thr_idx_nxt;
  logic [MARK_CNT_W-1:0]    mark_cnt_r, mark_cnt_nxt;
  logic [LEVEL_W-1:0]       q_r, q_nxt;
  logic [LEVEL_W-1:0]       mlvl_r, mlvl_nxt;
  logic [LEVEL_W-1:0]       target_r, target_nxt;
  logic                     forced_r, forced_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic                     out_load;

  // captured tick fields
  logic signed [MARGIN_W-1:0] m1_r, m2_r, m3_r;
  logic [LOAD_W-1:0]          load_r;
  logic signed [CDIFF_W-1:0]  rem_r, rem_nxt;
  logic                       grid_r, fault_r, poff_r;

  // output registers
  logic [DUTY_W-1:0]  out_duty_r;
  logic [PCT_W-1:0]   out_pct_r;
  logic [LEVEL_W-1:0] out_target_r;
  logic [LEVEL_W-1:0] out_applied_r;

  logic                      in_fire;
  logic signed [MSUM_W-1:0]  msum;
  logic                      eval_forced;
  logic [LEVEL_W-1:0]        mlvl_now;
  logic [LEVEL_W-1:0]        ll_pos;
  logic [LEVEL_W-1:0]        target_now;
  logic [CURR_W-1:0]         step_eff;
  logic [AVG_SUM_W-1:0]      load_thr [LOAD_MARKS];
  logic signed [ALU_W-1:0]   alu_a, alu_b, alu_diff;
  logic                      alu_ge;
  ramp_cmd_t                 ramp_cmd;
  logic [LEVEL_W-1:0]        ramp_level;
  logic [DUTY_W-1:0]         duty_sel;
  logic [PCT_PROD_W-1:0]     pct_prod;
  logic [PCT_PROD_W-1:0]     pct_quot;
  logic [PCT_W-1:0]          pct_val;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_delay_r    <= '0;
      fall_delay_r    <= '0;
      quiet_mode_r    <= '0;
      temp_lim_low_r  <= '0;
      temp_lim_high_r <= '0;
      cur_base_r      <= '0;
      cur_step_r      <= CURR_W'(1);
      duty_table_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_RISE_DELAY:      rise_delay_r    <= cfg_wdata[DELAY_W-1:0];
        CFG_FALL_DELAY:      fall_delay_r    <= cfg_wdata[DELAY_W-1:0];
        CFG_QUIET_MODE:      quiet_mode_r    <= cfg_wdata[QUIET_W-1:0];
        CFG_TEMP_LIMIT_LOW:  temp_lim_low_r  <= cfg_wdata[TEMP_W-1:0];
        CFG_TEMP_LIMIT_HIGH: temp_lim_high_r <= cfg_wdata[TEMP_W-1:0];
        CFG_CURRENT_BASE:    cur_base_r      <= cfg_wdata[CURR_W-1:0];
        CFG_CURRENT_STEP:    cur_step_r      <= cfg_wdata[CURR_W-1:0];
        CFG_DUTY_TABLE:      duty_table_r    <= cfg_wdata[DUTY_TBL_W-1:0];
        default: ;
      endcase
    end
  end

  // load thresholds scaled to the raw window sum
  always_comb begin
    for (int k = 0; k < LOAD_MARKS; k++) begin
      load_thr[k] = AVG_SUM_W'(LOAD_AVG_MARK[k] * AVG_WINDOW);
    end
  end

  assign step_eff = (cur_step_r == '0) ? CURR_W'(1) : cur_step_r;

  always_comb begin
    if (state_r == ST_LOAD) begin
      alu_a = {{(ALU_W-AVG_SUM_W){1'b0}}, avg_sum_r};
      alu_b = {{(ALU_W-AVG_SUM_W){1'b0}}, load_thr[thr_idx_r]};
    end else begin
      alu_a = {{(ALU_W-CDIFF_W){rem_r[CDIFF_W-1]}}, rem_r};
      alu_b = {{(ALU_W-CURR_W){1'b0}}, step_eff};
    end
  end

  tflr_alu u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .diff (alu_diff),
    .ge   (alu_ge)
  );

  assign msum = MSUM_W'(m1_r) + MSUM_W'(m2_r) + MSUM_W'(m3_r);
  assign eval_forced = (msum <= 15'sd0) || grid_r || fault_r;

  always_comb begin
    logic [LEVEL_W-1:0] l2;
    logic [LEVEL_W-1:0] l3;
    mlvl_now = margin_level(m1_r);
    l2 = margin_level(m2_r);
    l3 = margin_level(m3_r);
    if (l2 > mlvl_now) mlvl_now = l2;
    if (l3 > mlvl_now) mlvl_now = l3;
  end

  // a negative load or current level never wins against the margin level
  assign ll_pos = (load_level_r > 4'sd0) ? load_level_r[LEVEL_W-1:0] : '0;

  always_comb begin
    target_now = mlvl_r;
    if (ll_pos > target_now) target_now = ll_pos;
    if (q_r > target_now) target_now = q_r;
  end

  always_comb begin
    state_nxt      = state_r;
    avg_cnt_nxt    = avg_cnt_r;
    avg_sum_nxt    = avg_sum_r;
    load_level_nxt = load_level_r;
    thr_idx_nxt    = thr_idx_r;
    mark_cnt_nxt   = mark_cnt_r;
    q_nxt          = q_r;
    rem_nxt        = rem_r;
    mlvl_nxt       = mlvl_r;
    target_nxt     = target_r;
    forced_nxt     = forced_r;
    out_valid_nxt  = out_valid_r;
    out_load       = 1'b0;
    ramp_cmd       = '0;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          rem_nxt   = CDIFF_W'(in_battery_current) - CDIFF_W'(cur_base_r);
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        forced_nxt = eval_forced;
        mlvl_nxt   = mlvl_now;
        q_nxt      = '0;
        if (eval_forced) begin
          avg_cnt_nxt = '0;
          avg_sum_nxt = '0;
          state_nxt   = ST_RAMP;
        end else if (avg_cnt_r < AVG_CNT_W'(AVG_WINDOW)) begin
          avg_cnt_nxt = avg_cnt_r + AVG_CNT_W'(1);
          avg_sum_nxt = avg_sum_r + AVG_SUM_W'(load_r);
          state_nxt   = ST_DIV;
        end else begin
          thr_idx_nxt  = '0;
          mark_cnt_nxt = '0;
          state_nxt    = ST_LOAD;
        end
      end
      ST_LOAD: begin
        mark_cnt_nxt = mark_cnt_r + MARK_CNT_W'(alu_ge);
        if (thr_idx_r == THR_LAST) begin
          load_level_nxt = LLVL_W'(mark_cnt_nxt - MARK_CNT_W'(LOAD_LEVEL_BASE));
          avg_cnt_nxt    = '0;
          avg_sum_nxt    = '0;
          state_nxt      = ST_DIV;
        end else begin
          thr_idx_nxt = thr_idx_r + MARK_IDX_W'(1);
        end
      end
      ST_DIV: begin
        // restoring steps; quotient above 5 only ever clips to 5
        if (alu_ge && (q_r < LEVEL_MAX)) begin
          rem_nxt = alu_diff[CDIFF_W-1:0];
          q_nxt   = q_r + LEVEL_W'(1);
        end else begin
          state_nxt = ST_RAMP;
        end
      end
      ST_RAMP: begin
        target_nxt      = forced_r ? LEVEL_MAX : target_now;
        ramp_cmd.en     = 1'b1;
        ramp_cmd.forced = forced_r;
        ramp_cmd.poff   = poff_r;
        ramp_cmd.target = target_nxt;
        state_nxt       = ST_PCT;
      end
      ST_PCT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_load      = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      avg_cnt_r    <= '0;
      avg_sum_r    <= '0;
      load_level_r <= '0;
      target_r     <= '0;
      forced_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      avg_cnt_r    <= avg_cnt_nxt;
      avg_sum_r    <= avg_sum_nxt;
      load_level_r <= load_level_nxt;
      target_r     <= target_nxt;
      forced_r     <= forced_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    thr_idx_r  <= thr_idx_nxt;
    mark_cnt_r <= mark_cnt_nxt;
    q_r        <= q_nxt;
    rem_r      <= rem_nxt;
    mlvl_r     <= mlvl_nxt;
    if (in_fire) begin
      m1_r    <= MARGIN_W'(temp_lim_low_r) - MARGIN_W'(in_inverter_temp);
      m2_r    <= MARGIN_W'(temp_lim_high_r) - MARGIN_W'(in_converter_temp);
      m3_r    <= MARGIN_W'(temp_lim_low_r) - MARGIN_W'(in_charger_temp);
      load_r  <= in_load_percent;
      grid_r  <= in_grid_charge_flag;
      fault_r <= in_overtemp_fault;
      poff_r  <= in_power_off_test;
    end
  end

  tflr_ramp u_ramp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (ramp_cmd),
    .rise_delay (rise_delay_r),
    .fall_delay (fall_delay_r),
    .quiet_mode (quiet_mode_r),
    .level      (ramp_level)
  );

  always_comb begin
    duty_sel = '0;
    for (int k = 0; k < NUM_LEVELS; k++) begin
      if (ramp_level == LEVEL_W'(k)) duty_sel = duty_table_r[k*DUTY_W +: DUTY_W];
    end
  end

  assign pct_prod = PCT_PROD_W'(duty_sel) * PCT_PROD_W'(PCT_MUL);
  assign pct_quot = pct_prod >> PCT_SHIFT;
  assign pct_val  = (pct_quot > PCT_PROD_W'(PCT_SAT)) ? PCT_W'(PCT_SAT) : pct_quot[PCT_W-1:0];

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_duty_r    <= duty_sel;
      out_pct_r     <= pct_val;
      out_target_r  <= target_r;
      out_applied_r <= ramp_level;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_fan_duty      = out_duty_r;
  assign out_duty_percent  = out_pct_r;
  assign out_target_level  = out_target_r;
  assign out_applied_level = out_applied_r;

  `ASSERT_CHK_NR(a_rst_idle, !rst_n |=> !out_valid && in_ready, "reset left block busy")
  `ASSERT_CHK(a_accept_eval, in_valid && in_ready |=> state_r == ST_EVAL, "accepted tick not evaluated")
  `ASSERT_CHK(a_window_close, (state_r == ST_LOAD) && (thr_idx_r == THR_LAST) |=> (state_r == ST_DIV) && (avg_cnt_r == '0) && (avg_sum_r == '0), "averager not restarted")
  `ASSERT_CHK(a_pct_delivers, (state_r == ST_PCT) && !(out_valid && !out_ready) |=> out_valid && in_ready, "result not delivered")

endmodule
